>>> hdl/session_timer_with_auto_pause_core_assert.svh
// Assertion macros for the session timer core.
`ifndef SESSION_TIMER_WITH_AUTO_PAUSE_CORE_ASSERT_SVH
`define SESSION_TIMER_WITH_AUTO_PAUSE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define STMR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("session timer check failed");
`define STMR_ASSERT_NEVER(lbl, clk, rst_n, bad) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
    else $error("session timer check failed");
`else
`define STMR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define STMR_ASSERT_NEVER(lbl, clk, rst_n, bad)
`endif
`endif

>>> hdl/stmr_pkg.sv
`timescale 1ns / 1ps
package stmr_pkg;

  localparam int TIME_BITS = 40;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int MODE_W = 2;
  localparam int EV_W = 3;
  localparam int SEC_W = 31;
  localparam int MS_PER_SEC = 1000;

  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_IDX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_IDX = 1'd1;
  localparam logic [CFG_W-1:0] PAUSE_TIMEOUT_RST = 32'd10000;
  localparam logic [CFG_W-1:0] STOP_TIMEOUT_RST = 32'd300000;

  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STOP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STROKE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd3;

  localparam logic [EV_W-1:0] EV_NONE = 3'd0;
  localparam logic [EV_W-1:0] EV_STARTED = 3'd1;
  localparam logic [EV_W-1:0] EV_STOPPED = 3'd2;
  localparam logic [EV_W-1:0] EV_RESUMED = 3'd3;
  localparam logic [EV_W-1:0] EV_PAUSED = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [TIME_BITS-1:0] time_ms;
  } req_t;

  typedef struct packed {
    logic [EV_W-1:0]      event_res;
    logic                 is_active;
    logic                 is_running;
    logic                 is_paused;
    logic [TIME_BITS-1:0] elapsed_ms;
    logic [SEC_W-1:0]     elapsed_seconds;
  } res_t;

  typedef struct packed {
    logic [EV_W-1:0] ev;
    logic            active;
    logic            running;
    logic            paused;
  } tag_t;

  typedef struct packed {
    tag_t                 tag;
    logic                 cnt;
    logic [TIME_BITS-1:0] base;
    logic [TIME_BITS-1:0] ts;
    logic [TIME_BITS-1:0] pt;
  } snap_t;

  typedef struct packed {
    tag_t                 tag;
    logic [TIME_BITS-1:0] el;
  } meas_t;

endpackage

>>> hdl/stmr_ctrl.sv
`timescale 1ns / 1ps
module stmr_ctrl import stmr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  req_t                 req_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 snap_valid_o,
  input  logic                 snap_ready_i,
  output snap_t                snap_o
);

  typedef struct packed {
    logic                 active;
    logic                 running;
    logic                 paused;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] ts;
    logic [TIME_BITS-1:0] last;
    logic [TIME_BITS-1:0] pb;
    logic [TIME_BITS-1:0] pt;
  } st_t;

  logic                 req_valid_q;
  req_t                 req_q;
  logic                 snap_valid_q;
  snap_t                snap_q;
  snap_t                snap_d;
  st_t                  st_q;
  st_t                  st_d;
  logic [CFG_W-1:0]     pto_q;
  logic [CFG_W-1:0]     sto_q;
  logic [EV_W-1:0]      ev_d;
  logic                 rdy_req;
  logic                 rdy_snap;
  logic                 fire;
  logic [TIME_BITS-1:0] t;
  logic [TIME_BITS-1:0] last_gap;
  logic [TIME_BITS-1:0] pause_gap;
  logic [TIME_BITS:0]   pt_sum;
  logic [TIME_BITS-1:0] pt_sat;
  logic                 pause_hit;
  logic                 stop_hit;

  assign rdy_snap = !snap_valid_q || snap_ready_i;
  assign rdy_req = !req_valid_q || rdy_snap;
  assign fire = req_valid_q && rdy_snap;
  assign in_ready_o = rdy_req;
  assign snap_valid_o = snap_valid_q;
  assign snap_o = snap_q;

  assign t = req_q.time_ms;
  assign last_gap = (t > st_q.last) ? t - st_q.last : '0;
  assign pause_gap = (t > st_q.pb) ? t - st_q.pb : '0;
  assign pause_hit = (st_q.last != '0) && (last_gap > TIME_BITS'(pto_q));
  assign stop_hit = pause_gap > TIME_BITS'(sto_q);
  assign pt_sum = {1'b0, st_q.pt} + {1'b0, pause_gap};
  assign pt_sat = pt_sum[TIME_BITS] ? '1 : pt_sum[TIME_BITS-1:0];

  always_comb begin
    st_d = st_q;
    ev_d = EV_NONE;
    unique case (req_q.mode)
      MODE_START: begin
        if (!st_q.active) begin
          st_d = '0;
          st_d.active = 1'b1;
          ev_d = EV_STARTED;
        end
      end
      MODE_STOP: begin
        if (st_q.active) begin
          st_d.active = 1'b0;
          st_d.running = 1'b0;
          st_d.paused = 1'b0;
          ev_d = EV_STOPPED;
        end
      end
      MODE_STROKE: begin
        if (st_q.active) begin
          st_d.now = t;
          st_d.last = t;
          if (!st_q.running) begin
            st_d.running = 1'b1;
            st_d.ts = t;
            st_d.paused = 1'b0;
            st_d.pb = '0;
            st_d.pt = '0;
            ev_d = EV_RESUMED;
          end else if (st_q.paused) begin
            st_d.paused = 1'b0;
            if (st_q.pb != '0) begin
              st_d.pt = pt_sat;
              st_d.pb = '0;
              ev_d = EV_RESUMED;
            end
          end
        end
      end
      MODE_TICK: begin
        st_d.now = t;
        if (st_q.active && st_q.running) begin
          if (!st_q.paused && pause_hit) begin
            st_d.paused = 1'b1;
            st_d.pb = t;
            ev_d = EV_PAUSED;
          end else if (st_q.paused && stop_hit) begin
            st_d.active = 1'b0;
            st_d.running = 1'b0;
            st_d.paused = 1'b0;
            ev_d = EV_STOPPED;
          end
        end
      end
    endcase
  end

  always_comb begin
    snap_d.tag.ev = ev_d;
    snap_d.tag.active = st_d.active;
    snap_d.tag.running = st_d.running;
    snap_d.tag.paused = st_d.paused;
    snap_d.cnt = st_d.active && st_d.running;
    snap_d.base = (st_d.paused && (st_d.pb != '0)) ? st_d.pb : st_d.now;
    snap_d.ts = st_d.ts;
    snap_d.pt = st_d.pt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      snap_valid_q <= 1'b0;
      st_q <= '0;
      pto_q <= PAUSE_TIMEOUT_RST;
      sto_q <= STOP_TIMEOUT_RST;
    end else begin
      if (rdy_req) begin
        req_valid_q <= in_valid_i;
      end
      if (rdy_snap) begin
        snap_valid_q <= req_valid_q;
      end
      if (fire) begin
        st_q <= st_d;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PAUSE_IDX) begin
          pto_q <= cfg_data_i;
        end else if (cfg_idx_i == CFG_STOP_IDX) begin
          sto_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy_req) begin
      req_q <= req_i;
    end
    if (fire) begin
      snap_q <= snap_d;
    end
  end

endmodule

>>> hdl/stmr_elap.sv
`timescale 1ns / 1ps
module stmr_elap import stmr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  snap_valid_i,
  output logic  snap_ready_o,
  input  snap_t snap_i,
  output logic  meas_valid_o,
  input  logic  meas_ready_i,
  output meas_t meas_o
);

  typedef struct packed {
    tag_t                 tag;
    logic [TIME_BITS-1:0] d;
    logic [TIME_BITS-1:0] pt;
  } diff_t;

  logic  diff_valid_q;
  diff_t diff_q;
  diff_t diff_d;
  logic  meas_valid_q;
  meas_t meas_q;
  meas_t meas_d;
  logic  rdy_diff;
  logic  rdy_meas;

  assign rdy_meas = !meas_valid_q || meas_ready_i;
  assign rdy_diff = !diff_valid_q || rdy_meas;
  assign snap_ready_o = rdy_diff;
  assign meas_valid_o = meas_valid_q;
  assign meas_o = meas_q;

  always_comb begin
    diff_d.tag = snap_i.tag;
    diff_d.pt = snap_i.pt;
    diff_d.d = (snap_i.cnt && (snap_i.base >= snap_i.ts)) ? snap_i.base - snap_i.ts : '0;
    meas_d.tag = diff_q.tag;
    meas_d.el = (diff_q.d >= diff_q.pt) ? diff_q.d - diff_q.pt : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_valid_q <= 1'b0;
      meas_valid_q <= 1'b0;
    end else begin
      if (rdy_diff) begin
        diff_valid_q <= snap_valid_i;
      end
      if (rdy_meas) begin
        meas_valid_q <= diff_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_valid_i && rdy_diff) begin
      diff_q <= diff_d;
    end
    if (diff_valid_q && rdy_meas) begin
      meas_q <= meas_d;
    end
  end

endmodule

>>> hdl/stmr_div.sv
`timescale 1ns / 1ps
module stmr_div import stmr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  meas_valid_i,
  output logic  meas_ready_o,
  input  meas_t meas_i,
  output logic  res_valid_o,
  input  logic  res_ready_i,
  output res_t  res_o
);

  localparam int LO_W = TIME_BITS / 2;
  localparam int HI_W = TIME_BITS - LO_W;
  localparam int QH_W = LO_W - 9;
  localparam int R_W = 10;
  localparam int Y_W = LO_W + R_W;
  localparam int SH = Y_W + R_W;
  localparam int M_W = SH - 9;
  localparam int P_W = Y_W + M_W;
  localparam logic [63:0] LO_SPAN = 64'd1 << LO_W;
  localparam logic [63:0] DIVISOR = 64'(MS_PER_SEC);
  localparam logic [QH_W-1:0] LO_QUOT = QH_W'(LO_SPAN / DIVISOR);
  localparam logic [R_W-1:0] LO_REM = R_W'(LO_SPAN % DIVISOR);
  localparam logic [M_W-1:0] RECIP = M_W'(((64'd1 << SH) + DIVISOR - 64'd1) / DIVISOR);

  typedef struct packed {
    tag_t                 tag;
    logic [TIME_BITS-1:0] el;
    logic [SEC_W-1:0]     qh;
    logic [Y_W-1:0]       y;
  } split_t;

  typedef struct packed {
    tag_t                 tag;
    logic [TIME_BITS-1:0] el;
    logic [SEC_W-1:0]     q;
  } quot_t;

  logic            split_valid_q;
  split_t          split_q;
  split_t          split_d;
  logic            quot_valid_q;
  quot_t           quot_q;
  quot_t           quot_d;
  logic            rdy_split;
  logic            rdy_quot;
  logic [HI_W-1:0] xh;
  logic [LO_W-1:0] xl;
  logic [P_W-1:0]  prod;

  assign rdy_quot = !quot_valid_q || res_ready_i;
  assign rdy_split = !split_valid_q || rdy_quot;
  assign meas_ready_o = rdy_split;
  assign res_valid_o = quot_valid_q;

  // The upper half of the value holds whole thousands plus a remainder that is
  // folded into y. The rounded-up reciprocal divides y exactly over its range.
  assign xh = meas_i.el[TIME_BITS-1:LO_W];
  assign xl = meas_i.el[LO_W-1:0];
  assign prod = P_W'(split_q.y) * P_W'(RECIP);

  always_comb begin
    split_d.tag = meas_i.tag;
    split_d.el = meas_i.el;
    split_d.qh = SEC_W'(xh) * SEC_W'(LO_QUOT);
    split_d.y = Y_W'(xh) * Y_W'(LO_REM) + Y_W'(xl);
    quot_d.tag = split_q.tag;
    quot_d.el = split_q.el;
    quot_d.q = split_q.qh + SEC_W'(prod[P_W-1:SH]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_valid_q <= 1'b0;
      quot_valid_q <= 1'b0;
    end else begin
      if (rdy_split) begin
        split_valid_q <= meas_valid_i;
      end
      if (rdy_quot) begin
        quot_valid_q <= split_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (meas_valid_i && rdy_split) begin
      split_q <= split_d;
    end
    if (split_valid_q && rdy_quot) begin
      quot_q <= quot_d;
    end
  end

  always_comb begin
    res_o.event_res = quot_q.tag.ev;
    res_o.is_active = quot_q.tag.active;
    res_o.is_running = quot_q.tag.running;
    res_o.is_paused = quot_q.tag.paused;
    res_o.elapsed_ms = quot_q.el;
    res_o.elapsed_seconds = quot_q.q;
  end

endmodule

>>> hdl/session_timer_with_auto_pause_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_req_i (req_t)
// out       output     out_valid_o / out_ready_i  out_res_o (res_t)
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One request per cycle is accepted while the output is not stalled.
// The six register stages are the input register, the state update, two clamp
// stages and two stages of the divide-by-1000 unit, which uses a reciprocal multiply.
// Reset clears the session state and loads the default timeouts.
// A stalled output fills the empty stages before in_ready_o drops.
`include "session_timer_with_auto_pause_core_assert.svh"
module session_timer_with_auto_pause_core import stmr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  req_t                 in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output res_t                 out_res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;
  logic  meas_valid;
  logic  meas_ready;
  meas_t meas;

  stmr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_i       (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .snap_valid_o(snap_valid),
    .snap_ready_i(snap_ready),
    .snap_o      (snap)
  );

  stmr_elap u_elap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .snap_valid_i(snap_valid),
    .snap_ready_o(snap_ready),
    .snap_i      (snap),
    .meas_valid_o(meas_valid),
    .meas_ready_i(meas_ready),
    .meas_o      (meas)
  );

  stmr_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .meas_valid_i(meas_valid),
    .meas_ready_o(meas_ready),
    .meas_i      (meas),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (out_res_o)
  );

  `STMR_ASSERT_IMP(a_paused_implies_running, clk_i, rst_ni, out_valid_o && out_res_o.is_paused, out_res_o.is_running && out_res_o.is_active)
  `STMR_ASSERT_IMP(a_idle_elapsed_zero, clk_i, rst_ni, out_valid_o && !(out_res_o.is_active && out_res_o.is_running), out_res_o.elapsed_ms == '0)
  `STMR_ASSERT_IMP(a_started_not_running, clk_i, rst_ni, out_valid_o && (out_res_o.event_res == EV_STARTED), out_res_o.is_active && !out_res_o.is_running)
  `STMR_ASSERT_NEVER(a_seconds_match, clk_i, rst_ni, out_valid_o && (((TIME_BITS + 1)'(out_res_o.elapsed_seconds) * (TIME_BITS + 1)'(MS_PER_SEC) > (TIME_BITS + 1)'(out_res_o.elapsed_ms)) || ((TIME_BITS + 1)'(out_res_o.elapsed_seconds) * (TIME_BITS + 1)'(MS_PER_SEC) + (TIME_BITS + 1)'(MS_PER_SEC) <= (TIME_BITS + 1)'(out_res_o.elapsed_ms))))

endmodule
